// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every module that uses them has
// clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hw/rtl/sha1bs_pkg.sv =====
`default_nettype none

package sha1bs_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [31:0] ShaH0 = 32'h6745_2301;
  localparam logic [31:0] ShaH1 = 32'hEFCD_AB89;
  localparam logic [31:0] ShaH2 = 32'h98BA_DCFE;
  localparam logic [31:0] ShaH3 = 32'h1032_5476;
  localparam logic [31:0] ShaH4 = 32'hC3D2_E1F0;

  // Round constants, one per group of twenty rounds.
  localparam logic [3:0][31:0] RoundK = {
    32'hCA62_C1D6, 32'h8F1B_BCDC, 32'h6ED9_EBA1, 32'h5A82_7999
  };

  localparam logic [7:0] PadMark = 8'h80;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned ChainBits = 160;

  // Round function groups.
  localparam logic [1:0] FN_CHOOSE   = 2'd0;
  localparam logic [1:0] FN_PARITY   = 2'd1;
  localparam logic [1:0] FN_MAJORITY = 2'd2;
  localparam logic [1:0] FN_PARITY2  = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word0;
    logic [31:0] digest_word1;
    logic [31:0] digest_word2;
    logic [31:0] digest_word3;
    logic [31:0] digest_word4;
    logic        length_error;
  } out_item_t;

  // Work item kept in the queue between front and back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } q_entry_t;

  // Requests from the back end to the compression unit.
  typedef struct packed {
    logic start;
    logic init;
  } cmp_req_t;

  function automatic logic [31:0] round_f(input logic [1:0] sel, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] res;
    unique case (sel)
      FN_CHOOSE:   res = (b & c) | (~b & d);
      FN_MAJORITY: res = (b & c) | (b & d) | (c & d);
      FN_PARITY, FN_PARITY2: res = b ^ c ^ d;
      default:     res = b ^ c ^ d;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha1bs_front.sv =====
`default_nettype none

`include "assert_macros.svh"

module sha1bs_front #(
  parameter int unsigned Depth = sha1bs_pkg::QueueDepthDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire sha1bs_pkg::in_item_t item_i,
  output logic                      q_valid_o,
  output sha1bs_pkg::q_entry_t      q_item_o,
  input  wire logic                 q_pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sha1bs_pkg::q_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic accept, enq, deq;

  assign full      = (cnt_q == CntW'(Depth));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = mem_q[rd_ptr_q];

  assign accept = push && !full;
  // An item with neither a byte nor an end mark changes nothing and is dropped here.
  assign enq    = accept && (item_i.byte_valid || item_i.last);
  assign deq    = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (enq && !deq) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!enq && deq) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      mem_q[wr_ptr_q] <= '{data_byte: item_i.data_byte,
                           has_byte:  item_i.byte_valid,
                           last:      item_i.last};
    end
  end

  `ASSERT_CLK(front_cnt_bound, int'(cnt_q) <= int'(Depth), "queue count exceeds depth")

endmodule

`default_nettype wire

// ===== hw/rtl/sha1bs_compress.sv =====
`default_nettype none

`include "assert_macros.svh"

module sha1bs_compress (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire sha1bs_pkg::cmp_req_t                 req_i,
  input  wire logic [sha1bs_pkg::BlockBits-1:0]     block_i,
  output logic                                      busy_o,
  output logic [sha1bs_pkg::ChainBits-1:0]          chain_o
);

  localparam logic [6:0] LastRound = 7'd79;

  logic        run_q, fin_q;
  logic [6:0]  rnd_q;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h0_q, h1_q, h2_q, h3_q, h4_q;
  logic [sha1bs_pkg::BlockBits-1:0] w_q;

  logic [1:0]  fsel;
  logic [31:0] w_t, w_new, w_mix, tmp;

  assign busy_o  = run_q || fin_q;
  assign chain_o = {h0_q, h1_q, h2_q, h3_q, h4_q};

  always_comb begin
    if (rnd_q < 7'd20) begin
      fsel = sha1bs_pkg::FN_CHOOSE;
    end else if (rnd_q < 7'd40) begin
      fsel = sha1bs_pkg::FN_PARITY;
    end else if (rnd_q < 7'd60) begin
      fsel = sha1bs_pkg::FN_MAJORITY;
    end else begin
      fsel = sha1bs_pkg::FN_PARITY2;
    end
  end

  // The window holds w[t] .. w[t+15], with w[t] in the top word.
  assign w_t   = w_q[511:480];
  assign w_mix = w_q[95:64] ^ w_q[255:224] ^ w_q[447:416] ^ w_t;
  assign w_new = {w_mix[30:0], w_mix[31]};
  assign tmp   = {a_q[26:0], a_q[31:27]} + sha1bs_pkg::round_f(fsel, b_q, c_q, d_q)
                 + e_q + w_t + sha1bs_pkg::RoundK[fsel];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      fin_q <= 1'b0;
      rnd_q <= '0;
      h0_q  <= sha1bs_pkg::ShaH0;
      h1_q  <= sha1bs_pkg::ShaH1;
      h2_q  <= sha1bs_pkg::ShaH2;
      h3_q  <= sha1bs_pkg::ShaH3;
      h4_q  <= sha1bs_pkg::ShaH4;
    end else begin
      if (req_i.start) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end else if (run_q) begin
        if (rnd_q == LastRound) begin
          run_q <= 1'b0;
          fin_q <= 1'b1;
        end else begin
          rnd_q <= rnd_q + 1'b1;
        end
      end else if (fin_q) begin
        fin_q <= 1'b0;
        h0_q  <= h0_q + a_q;
        h1_q  <= h1_q + b_q;
        h2_q  <= h2_q + c_q;
        h3_q  <= h3_q + d_q;
        h4_q  <= h4_q + e_q;
      end else if (req_i.init) begin
        h0_q <= sha1bs_pkg::ShaH0;
        h1_q <= sha1bs_pkg::ShaH1;
        h2_q <= sha1bs_pkg::ShaH2;
        h3_q <= sha1bs_pkg::ShaH3;
        h4_q <= sha1bs_pkg::ShaH4;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= h0_q;
      b_q <= h1_q;
      c_q <= h2_q;
      d_q <= h3_q;
      e_q <= h4_q;
      w_q <= block_i;
    end else if (run_q) begin
      a_q <= tmp;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
      w_q <= {w_q[479:0], w_new};
    end
  end

  `ASSERT_NEVER(cmp_start_busy, req_i.start && busy_o, "compression started while busy")
  `ASSERT_NEVER(cmp_init_busy, req_i.init && busy_o, "chain reinitialized while busy")
  `ASSERT_CLK(cmp_finish, run_q && rnd_q == LastRound |=> fin_q && !run_q,
              "final chain update missing after last round")

endmodule

`default_nettype wire

// ===== hw/rtl/sha1bs_back.sv =====
`default_nettype none

`include "assert_macros.svh"

module sha1bs_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             q_valid_i,
  input  wire sha1bs_pkg::q_entry_t             q_item_i,
  output logic                                  q_pop_o,
  output sha1bs_pkg::cmp_req_t                  cmp_req_o,
  output logic [sha1bs_pkg::BlockBits-1:0]      cmp_block_o,
  input  wire logic                             cmp_busy_i,
  input  wire logic [sha1bs_pkg::ChainBits-1:0] chain_i,
  output logic                                  empty,
  input  wire logic                             pop,
  output sha1bs_pkg::out_item_t                 out_item_o
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_PAD  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  localparam logic [5:0] LastSlot   = 6'd63;
  localparam logic [5:0] LengthSlot = 6'd56;

  logic [1:0]  state_q, state_d;
  logic [1:0]  phase_q, phase_d;
  logic [2:0]  len_idx_q, len_idx_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] blen_q, blen_d;
  logic        ovf_q, ovf_d;
  logic [sha1bs_pkg::BlockBits-1:0] buf_q, buf_d;
  logic        out_valid_q, out_valid_d;
  sha1bs_pkg::out_item_t out_q, out_d;

  logic        feed_en;
  logic [7:0]  feed_byte;
  logic        blocked, take_byte, load_out;
  logic [64:0] blen_sum;

  assign blen_sum    = {1'b0, blen_q} + 65'd8;
  // The byte that fills the buffer hands the block over, so the unit must be free.
  assign blocked     = (cnt_q == LastSlot) && cmp_busy_i;
  assign take_byte   = q_item_i.has_byte && !ovf_q;
  assign cmp_block_o = {buf_q[sha1bs_pkg::BlockBits-9:0], feed_byte};

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    len_idx_d = len_idx_q;
    blen_d    = blen_q;
    ovf_d     = ovf_q;
    feed_en   = 1'b0;
    feed_byte = q_item_i.data_byte;
    q_pop_o   = 1'b0;
    load_out  = 1'b0;
    cmp_req_o = '0;

    unique case (state_q)
      ST_RUN: begin
        if (q_valid_i && !(take_byte && blocked)) begin
          q_pop_o = 1'b1;
          if (take_byte) begin
            feed_en = 1'b1;
            blen_d  = blen_sum[63:0];
            ovf_d   = blen_sum[64];
          end
          if (q_item_i.last) begin
            state_d   = ovf_d ? ST_DONE : ST_PAD;
            phase_d   = PH_MARK;
            len_idx_d = '0;
          end
        end
      end
      ST_PAD: begin
        if (!blocked) begin
          case (phase_q)
            PH_MARK: begin
              feed_en   = 1'b1;
              feed_byte = sha1bs_pkg::PadMark;
              phase_d   = PH_ZERO;
            end
            PH_ZERO: begin
              if (cnt_q == LengthSlot) begin
                phase_d = PH_LEN;
              end else begin
                feed_en   = 1'b1;
                feed_byte = '0;
              end
            end
            default: begin
              feed_en   = 1'b1;
              feed_byte = blen_q[{~len_idx_q, 3'b000} +: 8];
              if (len_idx_q == 3'd7) begin
                state_d = ST_DONE;
              end else begin
                len_idx_d = len_idx_q + 1'b1;
              end
            end
          endcase
        end
      end
      ST_DONE: begin
        if (!cmp_busy_i && (!out_valid_q || pop)) begin
          load_out       = 1'b1;
          cmp_req_o.init = 1'b1;
          blen_d         = '0;
          ovf_d          = 1'b0;
          state_d        = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase

    buf_d = buf_q;
    cnt_d = cnt_q;
    if (feed_en) begin
      buf_d = cmp_block_o;
      cnt_d = cnt_q + 1'b1;
      cmp_req_o.start = (cnt_q == LastSlot);
    end
    if (load_out) begin
      cnt_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load_out) begin
      out_valid_d        = 1'b1;
      out_d.digest_word0 = ovf_q ? '0 : chain_i[159:128];
      out_d.digest_word1 = ovf_q ? '0 : chain_i[127:96];
      out_d.digest_word2 = ovf_q ? '0 : chain_i[95:64];
      out_d.digest_word3 = ovf_q ? '0 : chain_i[63:32];
      out_d.digest_word4 = ovf_q ? '0 : chain_i[31:0];
      out_d.length_error = ovf_q;
    end else if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      phase_q     <= PH_MARK;
      len_idx_q   <= '0;
      cnt_q       <= '0;
      blen_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      len_idx_q   <= len_idx_d;
      cnt_q       <= cnt_d;
      blen_q      <= blen_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    out_q <= out_d;
  end

  `ASSERT_CLK(back_err_zero, out_valid_q && out_q.length_error |->
              out_q.digest_word0 == '0 && out_q.digest_word4 == '0,
              "error result carries a nonzero digest")
  `ASSERT_NEVER(back_pad_overflow, state_q == ST_PAD && ovf_q,
                "padding entered after a length overflow")

endmodule

`default_nettype wire

// ===== hw/rtl/sha1_byte_stream_hash.sv =====
// SHA-1 over a byte stream, one message after another.
// Input queue: present an item on in_item_i with push high; it transfers on
// a clock edge where push is high and full is low. byte_valid appends
// data_byte to the message, last closes the message (a byte on the same
// item is appended first).
// Result queue: while empty is low, out_item_o holds the digest of the
// oldest finished message; it transfers on an edge where pop is high.
// length_error is set, with all digest words zero, if the bit length
// reached 2^64.
// Bytes enter a 64-byte shift buffer at one per cycle, but the byte that
// fills the buffer waits while the compression unit is busy. A full block
// is handed to the compression unit, which runs 80 rounds at one per cycle
// and then the chain update while the next block fills. After last,
// padding feeds up to 72 more bytes, then one or two compressions follow;
// the digest is loaded into the output register once the last one is done.
// If pop stays low, the finished digest waits in the output register and
// the input queue keeps taking items until it fills. Reset clears the queue,
// the length and the chain value; no digest is pending after reset.
`default_nettype none

module sha1_byte_stream_hash #(
  parameter int unsigned QueueDepth = sha1bs_pkg::QueueDepthDefault
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push,
  output logic                       full,
  input  wire sha1bs_pkg::in_item_t  in_item_i,
  output logic                       empty,
  input  wire logic                  pop,
  output sha1bs_pkg::out_item_t      out_item_o
);

  logic                                 q_valid, q_pop;
  sha1bs_pkg::q_entry_t                 q_item;
  sha1bs_pkg::cmp_req_t                 cmp_req;
  logic [sha1bs_pkg::BlockBits-1:0]     cmp_block;
  logic                                 cmp_busy;
  logic [sha1bs_pkg::ChainBits-1:0]     chain;

  sha1bs_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .item_i    (in_item_i),
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  sha1bs_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (cmp_req),
    .block_i (cmp_block),
    .busy_o  (cmp_busy),
    .chain_o (chain)
  );

  sha1bs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .cmp_req_o   (cmp_req),
    .cmp_block_o (cmp_block),
    .cmp_busy_i  (cmp_busy),
    .chain_i     (chain),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

// ===== tb/sha1_byte_stream_hash_tb.sv =====
`default_nettype none

module sha1_byte_stream_hash_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    sha1bs_pkg::in_item_t  item;
    logic                  known;
    sha1bs_pkg::out_item_t want;
  } dir_row_t;

  localparam sha1bs_pkg::out_item_t NoDigest = '0;
  localparam sha1bs_pkg::out_item_t EmptyDigest = '{
    32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709, 1'b0
  };
  localparam sha1bs_pkg::out_item_t AbcDigest = '{
    32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d, 1'b0
  };

  // Short messages with known digests, extreme bytes, ignored items, and
  // a closing item that carries no byte.
  localparam dir_row_t DirRows [18] = '{
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, EmptyDigest},
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, NoDigest},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, NoDigest},
    '{'{8'h63, 1'b1, 1'b1}, 1'b1, AbcDigest},
    '{'{8'hAA, 1'b0, 1'b1}, 1'b1, EmptyDigest},
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, NoDigest},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, NoDigest},
    '{'{8'h63, 1'b1, 1'b0}, 1'b0, NoDigest},
    '{'{8'h55, 1'b0, 1'b1}, 1'b1, AbcDigest},
    '{'{8'hFF, 1'b1, 1'b0}, 1'b0, NoDigest},
    '{'{8'h00, 1'b1, 1'b1}, 1'b0, NoDigest},
    '{'{8'h5A, 1'b0, 1'b0}, 1'b0, NoDigest},
    '{'{8'hA5, 1'b0, 1'b0}, 1'b0, NoDigest},
    '{'{8'hFF, 1'b1, 1'b1}, 1'b0, NoDigest},
    '{'{8'h3C, 1'b1, 1'b0}, 1'b0, NoDigest},
    '{'{8'hC3, 1'b0, 1'b1}, 1'b0, NoDigest},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, NoDigest},
    '{'{8'h00, 1'b1, 1'b1}, 1'b0, NoDigest}
  };

  // Message lengths around the padding and block edges.
  localparam int Boundary [7] = '{55, 56, 63, 64, 119, 120, 128};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  push = 1'b0;
  logic                  pop = 1'b0;
  logic                  full;
  logic                  empty;
  sha1bs_pkg::in_item_t  in_item = '0;
  sha1bs_pkg::out_item_t out_item;

  // Predictor state.
  logic [7:0]  msg_buf [64];
  logic [5:0]  msg_fill;
  logic [63:0] msg_bits;
  logic [31:0] hash_state [5];
  logic        len_wrapped;

  sha1bs_pkg::out_item_t pending_digests [$];
  sha1bs_pkg::out_item_t want_dig;
  int        mismatches = 0;
  int        items_sent = 0;
  int        pop_hold = 0;
  bit        calm = 1'b0;

  sha1_byte_stream_hash u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #100_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void hash_restart();
    msg_fill = '0;
    msg_bits = '0;
    len_wrapped = 1'b0;
    hash_state[0] = sha1bs_pkg::ShaH0;
    hash_state[1] = sha1bs_pkg::ShaH1;
    hash_state[2] = sha1bs_pkg::ShaH2;
    hash_state[3] = sha1bs_pkg::ShaH3;
    hash_state[4] = sha1bs_pkg::ShaH4;
  endfunction

  function automatic void hash_block(input logic [511:0] blk);
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, tmp;
    for (int t = 0; t < 16; t++) w[t] = blk[511 - 32 * t -: 32];
    for (int t = 16; t < 80; t++) begin
      tmp = w[t - 3] ^ w[t - 8] ^ w[t - 14] ^ w[t - 16];
      w[t] = {tmp[30:0], tmp[31]};
    end
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
      end else if (t >= 40 && t < 60) begin
        f = (b & c) | (b & d) | (c & d);
      end else begin
        f = b ^ c ^ d;
      end
      tmp = {a[26:0], a[31:27]} + f + e + w[t] + sha1bs_pkg::RoundK[t / 20];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = tmp;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  // Absorbs one accepted item; returns 1 when it closes a message.
  // The length wrap needs 2^61 bytes, so a run never gets there.
  function automatic bit hash_absorb(input sha1bs_pkg::in_item_t it,
                                     output sha1bs_pkg::out_item_t dig);
    logic [511:0] blk;
    int n;
    dig = '0;
    if (it.byte_valid && !len_wrapped) begin
      msg_buf[msg_fill] = it.data_byte;
      msg_bits += 64'd8;
      if (msg_bits == 64'd0) len_wrapped = 1'b1;
      if (msg_fill == 6'd63) begin
        for (int i = 0; i < 64; i++) blk[511 - 8 * i -: 8] = msg_buf[i];
        hash_block(blk);
      end
      msg_fill++;
    end
    if (!it.last) return 1'b0;
    if (len_wrapped) begin
      dig.length_error = 1'b1;
    end else begin
      n = msg_fill;
      blk = '0;
      for (int i = 0; i < n; i++) blk[511 - 8 * i -: 8] = msg_buf[i];
      blk[511 - 8 * n -: 8] = sha1bs_pkg::PadMark;
      if (n > 55) begin
        hash_block(blk);
        blk = '0;
      end
      blk[63:0] = msg_bits;
      hash_block(blk);
      dig.digest_word0 = hash_state[0];
      dig.digest_word1 = hash_state[1];
      dig.digest_word2 = hash_state[2];
      dig.digest_word3 = hash_state[3];
      dig.digest_word4 = hash_state[4];
    end
    hash_restart();
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(0, 12);
    if (r < 70) return Boundary[$urandom_range(0, 6)] + int'($urandom_range(0, 2)) - 1;
    if (r < 92) return $urandom_range(13, 130);
    return $urandom_range(131, 260);
  endfunction

  task automatic send_item(input sha1bs_pkg::in_item_t it, input bit known,
                           input sha1bs_pkg::out_item_t want);
    int gap;
    sha1bs_pkg::out_item_t dig;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    if (hash_absorb(it, dig)) pending_digests.push_back(known ? want : dig);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Some messages run with no idling on either side.
  task automatic send_message(input int len);
    bit carry;
    sha1bs_pkg::in_item_t it;
    calm = ($urandom_range(0, 3) == 0);
    carry = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len - int'(carry); i++) begin
      if ($urandom_range(0, 99) < 8) begin
        it = '{8'($urandom), 1'b0, 1'b0};
        send_item(it, 1'b0, NoDigest);
      end
      it = '{8'($urandom), 1'b1, 1'b0};
      send_item(it, 1'b0, NoDigest);
    end
    it = '{8'($urandom), carry, 1'b1};
    send_item(it, 1'b0, NoDigest);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(negedge clk_i) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold--;
    end else begin
      pop <= 1'b1;
      pop_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (pending_digests.size() == 0) begin
        $error("digest transfer with none pending: %h", out_item);
        mismatches++;
      end else begin
        want_dig = pending_digests.pop_front();
        check_field("digest_word0", want_dig.digest_word0, out_item.digest_word0);
        check_field("digest_word1", want_dig.digest_word1, out_item.digest_word1);
        check_field("digest_word2", want_dig.digest_word2, out_item.digest_word2);
        check_field("digest_word3", want_dig.digest_word3, out_item.digest_word3);
        check_field("digest_word4", want_dig.digest_word4, out_item.digest_word4);
        check_field("length_error", 32'(want_dig.length_error), 32'(out_item.length_error));
      end
    end
  end

  initial begin
    hash_restart();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (DirRows[i]) send_item(DirRows[i].item, DirRows[i].known, DirRows[i].want);
    foreach (Boundary[i]) send_message(Boundary[i]);
    while (items_sent < 1320) send_message(pick_length());
    push <= 1'b0;
    calm = 1'b0;
    while (pending_digests.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
